// ----- sv/mdu_pkg.sv -----
// Shared types, operation codes and sizing constants for the RV64M multiply/divide unit.
`timescale 1ns / 1ps

package mdu_pkg;

    localparam int XLEN       = 64;
    localparam int HALF       = XLEN / 2;
    localparam int DIV_STEPS  = XLEN;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] FUNC_MUL    = 4'd0;
    localparam logic [3:0] FUNC_MULH   = 4'd1;
    localparam logic [3:0] FUNC_MULHSU = 4'd2;
    localparam logic [3:0] FUNC_MULHU  = 4'd3;
    localparam logic [3:0] FUNC_DIV    = 4'd4;
    localparam logic [3:0] FUNC_DIVU   = 4'd5;
    localparam logic [3:0] FUNC_REM    = 4'd6;
    localparam logic [3:0] FUNC_REMU   = 4'd7;
    localparam logic [3:0] FUNC_MULW   = 4'd8;
    localparam logic [3:0] FUNC_DIVW   = 4'd9;
    localparam logic [3:0] FUNC_DIVUW  = 4'd10;
    localparam logic [3:0] FUNC_REMW   = 4'd11;
    localparam logic [3:0] FUNC_REMUW  = 4'd12;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic [3:0]      func;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
        logic [4:0]      dest_reg;
    } req_t;

    typedef struct packed {
        logic [XLEN-1:0] result_value;
        logic [4:0]      dest_reg_out;
    } res_t;

    // Classified request handed from the front end to the execution pipeline.
    typedef struct packed {
        kind_t           kind;
        logic            word;
        logic            sel_hi;
        logic            sel_rem;
        logic            neg_q;
        logic            neg_r;
        logic [XLEN-1:0] mag_a;
        logic [XLEN-1:0] mag_b;
        logic [4:0]      dest;
    } job_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               push;
        logic               pop;
    } fifo_stat_t;

endpackage

// ----- sv/mdu_front.sv -----
// Front end: accepts requests, decodes the operation and forms operand magnitudes and signs.
`timescale 1ns / 1ps

module mdu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mdu_pkg::req_t s_request,
    output logic          job_valid,
    input  logic          job_ready,
    output mdu_pkg::job_t job
);

    mdu_pkg::kind_t kind;
    logic word, sel_hi, sel_rem, sgn_a, sgn_b;
    logic [mdu_pkg::XLEN-1:0] opa, opb;
    logic a_neg, b_neg, b_zero;
    mdu_pkg::job_t job_next, job_reg;
    logic valid_reg;

    always_comb begin
        kind    = mdu_pkg::KIND_NONE;
        word    = 1'b0;
        sel_hi  = 1'b0;
        sel_rem = 1'b0;
        sgn_a   = 1'b0;
        sgn_b   = 1'b0;
        unique case (s_request.func)
            mdu_pkg::FUNC_MUL: begin
                kind = mdu_pkg::KIND_MUL;
            end
            mdu_pkg::FUNC_MULH: begin
                kind = mdu_pkg::KIND_MUL; sel_hi = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1;
            end
            mdu_pkg::FUNC_MULHSU: begin
                kind = mdu_pkg::KIND_MUL; sel_hi = 1'b1; sgn_a = 1'b1;
            end
            mdu_pkg::FUNC_MULHU: begin
                kind = mdu_pkg::KIND_MUL; sel_hi = 1'b1;
            end
            mdu_pkg::FUNC_DIV: begin
                kind = mdu_pkg::KIND_DIV; sgn_a = 1'b1; sgn_b = 1'b1;
            end
            mdu_pkg::FUNC_DIVU: begin
                kind = mdu_pkg::KIND_DIV;
            end
            mdu_pkg::FUNC_REM: begin
                kind = mdu_pkg::KIND_DIV; sel_rem = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1;
            end
            mdu_pkg::FUNC_REMU: begin
                kind = mdu_pkg::KIND_DIV; sel_rem = 1'b1;
            end
            mdu_pkg::FUNC_MULW: begin
                kind = mdu_pkg::KIND_MUL; word = 1'b1;
            end
            mdu_pkg::FUNC_DIVW: begin
                kind = mdu_pkg::KIND_DIV; word = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1;
            end
            mdu_pkg::FUNC_DIVUW: begin
                kind = mdu_pkg::KIND_DIV; word = 1'b1;
            end
            mdu_pkg::FUNC_REMW: begin
                kind = mdu_pkg::KIND_DIV; word = 1'b1; sel_rem = 1'b1;
                sgn_a = 1'b1; sgn_b = 1'b1;
            end
            mdu_pkg::FUNC_REMUW: begin
                kind = mdu_pkg::KIND_DIV; word = 1'b1; sel_rem = 1'b1;
            end
            default: begin
                kind = mdu_pkg::KIND_NONE;
            end
        endcase
    end

    always_comb begin
        if (word) begin
            opa = {{mdu_pkg::HALF{sgn_a & s_request.operand_a[mdu_pkg::HALF-1]}},
                   s_request.operand_a[mdu_pkg::HALF-1:0]};
            opb = {{mdu_pkg::HALF{sgn_b & s_request.operand_b[mdu_pkg::HALF-1]}},
                   s_request.operand_b[mdu_pkg::HALF-1:0]};
        end else begin
            opa = s_request.operand_a;
            opb = s_request.operand_b;
        end
        a_neg  = sgn_a & opa[mdu_pkg::XLEN-1];
        b_neg  = sgn_b & opb[mdu_pkg::XLEN-1];
        b_zero = (opb == '0);

        job_next.kind    = kind;
        job_next.word    = word;
        job_next.sel_hi  = sel_hi;
        job_next.sel_rem = sel_rem;
        // A zero divisor yields an all-ones quotient, which must not be negated.
        job_next.neg_q   = (a_neg ^ b_neg) & ~((kind == mdu_pkg::KIND_DIV) & b_zero);
        job_next.neg_r   = a_neg;
        job_next.mag_a   = a_neg ? (mdu_pkg::XLEN'(0) - opa) : opa;
        job_next.mag_b   = b_neg ? (mdu_pkg::XLEN'(0) - opb) : opb;
        job_next.dest    = s_request.dest_reg;
    end

    assign s_ready   = ~valid_reg | job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- sv/mdu_fifo.sv -----
// Short request queue between the front end and the execution pipeline.
`timescale 1ns / 1ps

module mdu_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mdu_pkg::job_t       in_job,
    output logic                out_valid,
    input  logic                out_ready,
    output mdu_pkg::job_t       out_job,
    output mdu_pkg::fifo_stat_t stat
);

    mdu_pkg::job_t mem [mdu_pkg::FIFO_DEPTH];
    logic [mdu_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mdu_pkg::FIFO_CW-1:0] count_reg, count_next;
    logic push, pop;

    assign in_ready  = (count_reg != mdu_pkg::FIFO_CW'(mdu_pkg::FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign stat.count = count_reg;
    assign stat.push  = push;
    assign stat.pop   = pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ----- sv/mdu_back.sv -----
// Execution pipeline: partial-product multiplier and one-bit-per-stage restoring divider.
`timescale 1ns / 1ps

module mdu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  mdu_pkg::job_t job,
    output logic          m_valid,
    input  logic          m_ready,
    output mdu_pkg::res_t m_result
);

    typedef struct packed {
        mdu_pkg::kind_t           kind;
        logic                     word;
        logic                     sel_hi;
        logic                     sel_rem;
        logic                     neg_q;
        logic                     neg_r;
        logic [mdu_pkg::XLEN-1:0] quo;
        logic [mdu_pkg::XLEN-1:0] rem;
        logic [mdu_pkg::XLEN-1:0] dvs;
        logic [mdu_pkg::XLEN-1:0] aux;
        logic [4:0]               dest;
    } stage_t;

    localparam int H = mdu_pkg::HALF;
    localparam int X = mdu_pkg::XLEN;

    stage_t stage_reg [mdu_pkg::DIV_STEPS + 1];
    stage_t step_next [mdu_pkg::DIV_STEPS];
    logic   valid_reg [mdu_pkg::DIV_STEPS + 1];
    stage_t entry_next;
    logic   en;
    logic   out_valid_reg;
    mdu_pkg::res_t out_reg, out_next;

    assign en        = ~out_valid_reg | m_ready;
    assign job_ready = en;

    always_comb begin
        entry_next.kind    = job.kind;
        entry_next.word    = job.word;
        entry_next.sel_hi  = job.sel_hi;
        entry_next.sel_rem = job.sel_rem;
        entry_next.neg_q   = job.neg_q;
        entry_next.neg_r   = job.neg_r;
        entry_next.dest    = job.dest;
        if (job.kind == mdu_pkg::KIND_MUL) begin
            // Four 32x32 partial products of the operand magnitudes.
            entry_next.quo = X'(job.mag_a[H-1:0]) * X'(job.mag_b[H-1:0]);
            entry_next.rem = X'(job.mag_a[H-1:0]) * X'(job.mag_b[X-1:H]);
            entry_next.dvs = X'(job.mag_a[X-1:H]) * X'(job.mag_b[H-1:0]);
            entry_next.aux = X'(job.mag_a[X-1:H]) * X'(job.mag_b[X-1:H]);
        end else begin
            entry_next.quo = job.mag_a;
            entry_next.rem = '0;
            entry_next.dvs = job.mag_b;
            entry_next.aux = '0;
        end
    end

    for (genvar i = 0; i < mdu_pkg::DIV_STEPS; i++) begin : g_step
        logic [X:0]     partial;
        logic [X:0]     diff;
        logic           ge;
        logic [2*X-1:0] prod;

        always_comb begin
            step_next[i] = stage_reg[i];
            partial = {stage_reg[i].rem, stage_reg[i].quo[X-1]};
            diff    = partial - {1'b0, stage_reg[i].dvs};
            ge      = (partial >= {1'b0, stage_reg[i].dvs});
            prod    = '0 - {stage_reg[i].rem, stage_reg[i].quo};
            if (stage_reg[i].kind == mdu_pkg::KIND_DIV) begin
                step_next[i].rem = ge ? diff[X-1:0] : partial[X-1:0];
                step_next[i].quo = {stage_reg[i].quo[X-2:0], ge};
            end else if (stage_reg[i].kind == mdu_pkg::KIND_MUL) begin
                if (i == 0) begin
                    // Middle column sum and the upper-word partial sum.
                    step_next[i].rem = X'(stage_reg[i].quo[X-1:H]) + X'(stage_reg[i].rem[H-1:0])
                                     + X'(stage_reg[i].dvs[H-1:0]);
                    step_next[i].aux = stage_reg[i].aux + X'(stage_reg[i].rem[X-1:H])
                                     + X'(stage_reg[i].dvs[X-1:H]);
                end else if (i == 1) begin
                    step_next[i].rem = stage_reg[i].aux + X'(stage_reg[i].rem[X-1:H]);
                    step_next[i].quo = {stage_reg[i].rem[H-1:0], stage_reg[i].quo[H-1:0]};
                end else if (i == 2) begin
                    if (stage_reg[i].neg_q) begin
                        step_next[i].rem = prod[2*X-1:X];
                        step_next[i].quo = prod[X-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        stage_t           last;
        logic [X-1:0]     value;
        last  = stage_reg[mdu_pkg::DIV_STEPS];
        value = '0;
        case (last.kind)
            mdu_pkg::KIND_MUL: value = last.sel_hi ? last.rem : last.quo;
            mdu_pkg::KIND_DIV: begin
                if (last.sel_rem) begin
                    value = last.neg_r ? (X'(0) - last.rem) : last.rem;
                end else begin
                    value = last.neg_q ? (X'(0) - last.quo) : last.quo;
                end
            end
            default: value = '0;
        endcase
        if (last.word) begin
            value = {{H{value[H-1]}}, value[H-1:0]};
        end
        out_next.result_value = value;
        out_next.dest_reg_out = last.dest;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= mdu_pkg::DIV_STEPS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0]  <= job_valid;
            for (int k = 0; k < mdu_pkg::DIV_STEPS; k++) begin
                valid_reg[k+1] <= valid_reg[k];
            end
            out_valid_reg <= valid_reg[mdu_pkg::DIV_STEPS];
        end
        if (en) begin
            stage_reg[0] <= entry_next;
            for (int k = 0; k < mdu_pkg::DIV_STEPS; k++) begin
                stage_reg[k+1] <= step_next[k];
            end
            out_reg <= out_next;
        end
    end

endmodule

// ----- sv/rv64m_multiply_divide_unit_top.sv -----
// Top level of the RV64M multiply/divide unit: front end, request queue and execution pipeline.
// Path: a request passes through the front register, the queue write, the product entry
// stage, 64 divider stages and the output register before its result can be taken.
// Throughput: one request per cycle for every operation unless m_ready stalls the pipeline.
// The 64-stage divider sets the latency.
// Reset: synchronous, active-low aresetn empties the front register, queue and pipeline valids.
`timescale 1ns / 1ps

module rv64m_multiply_divide_unit_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mdu_pkg::req_t s_request,
    output logic          m_valid,
    input  logic          m_ready,
    output mdu_pkg::res_t m_result
);

    // The front end decodes each request into a job: operation class, result selection,
    // W-form flag, operand magnitudes and the signs to apply at the end.
    logic                fr_valid, fr_ready;
    mdu_pkg::job_t       fr_job;

    // The queue lets the front end keep taking requests while the pipeline is stalled.
    logic                bk_valid, bk_ready;
    mdu_pkg::job_t       bk_job;
    mdu_pkg::fifo_stat_t q_stat;

    mdu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_request (s_request),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    mdu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_job    (fr_job),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_job   (bk_job),
        .stat      (q_stat)
    );

    // The execution pipeline advances as a whole whenever its output register is free
    // or being emptied, so results leave in request order.
    mdu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (bk_valid),
        .job_ready (bk_ready),
        .job       (bk_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= mdu_pkg::FIFO_CW'(mdu_pkg::FIFO_DEPTH))
        else $error("request queue count exceeds its depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.pop |-> (q_stat.count != '0))
        else $error("request queue popped while empty");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.push && !q_stat.pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("request queue count lost a push");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
